@@ src/text_console_cursor_scroll_defines.svh @@
// ============================================================================
// text_console_cursor_scroll_defines.svh
// Assertion macros used by the console top module.
// ============================================================================
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define TCCS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define TCCS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TCCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/tccs_pkg.sv @@
// ============================================================================
// tccs_pkg
// Geometry, field widths, codes and shared types of the text console.
// ============================================================================
`timescale 1ns / 1ps

package tccs_pkg;

    // Screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;

    // Internal widths
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int CNT_W  = $clog2(CELL_COUNT + 1);
    localparam int SUM_W  = $clog2(CELL_COUNT + COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    // Port field widths
    localparam int MODE_W    = 2;
    localparam int CHAR_W    = 8;
    localparam int IDX_W     = 11;
    localparam int COLOR_W   = 8;
    localparam int CELL_W    = 16;
    localparam int OUT_ROW_W = 5;
    localparam int OUT_COL_W = 7;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    // Character and attribute constants
    localparam logic [CHAR_W-1:0]  NEWLINE_CODE   = 8'd10;
    localparam logic [CHAR_W-1:0]  BLANK_CODE     = 8'd32;
    localparam logic [COLOR_W-1:0] COLOR_AT_RESET = 8'h07;

    // Control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ_WAIT,
        ST_SWEEP
    } t_state;

    // What a full-screen sweep writes into each cell
    typedef enum logic [1:0] {
        FILL_COPY,   // scroll: cell takes the one a row below, bottom row blank
        FILL_BLANK,  // clear: blanks in current color
        FILL_ZERO    // power-up clear
    } t_fill;

    // Cell store access, one write and one read port
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

@@ src/tccs_cell_store.sv @@
// ============================================================================
// tccs_cell_store
// Screen cell memory: one write and one read per cycle, registered read data.
// ============================================================================
`timescale 1ns / 1ps

module tccs_cell_store (
    input  logic                       i_clk,
    input  tccs_pkg::t_mem_req         i_req,
    output logic [tccs_pkg::CELL_W-1:0] o_rdata
);
    import tccs_pkg::*;

    logic [CELL_W-1:0] r_mem [CELL_COUNT];
    logic [CELL_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/text_console_cursor_scroll.sv @@
// ============================================================================
// text_console_cursor_scroll
// Text-mode console: 80x25 cell store with cursor, newline, wrap and scroll.
// ============================================================================
// Commands are taken when i_start is high and o_busy is low; every command
// gives one result, shown for a single cycle with o_strobe, and it cannot be
// held off. A put, newline, unused mode or out-of-range read passes through
// accept and execute, and the result strobe overlaps the next accept slot. A
// read of a valid cell adds a wait state for the registered read data of the
// cell RAM. A clear, or a put that moves past the last row and scrolls,
// walks every cell through the RAM read/write ports one cell per cycle.
// After reset the cell RAM is zeroed by the same walk, with o_busy high;
// color writes are taken during it.
// ============================================================================
`timescale 1ns / 1ps
`include "text_console_cursor_scroll_defines.svh"

module text_console_cursor_scroll (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command channel
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [tccs_pkg::MODE_W-1:0]    i_mode,
    input  logic [tccs_pkg::CHAR_W-1:0]    i_char_code,
    input  logic [tccs_pkg::IDX_W-1:0]     i_cell_index,
    // result channel
    output logic                           o_strobe,
    output logic [tccs_pkg::OUT_ROW_W-1:0] o_cursor_row,
    output logic [tccs_pkg::OUT_COL_W-1:0] o_cursor_column,
    output logic [tccs_pkg::CELL_W-1:0]    o_cell_value,
    // color register write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tccs_pkg::COLOR_W-1:0]   i_cfg_data
);
    import tccs_pkg::*;

    // Sequencer
    t_state r_state, n_state;

    // Latched command
    logic [MODE_W-1:0] r_mode;
    logic [CHAR_W-1:0] r_char;
    logic [IDX_W-1:0]  r_idx;

    // Cursor and row start address
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ADDR_W-1:0] r_row_base, n_row_base;

    // Color register
    logic [COLOR_W-1:0] r_color;

    // Sweep engine
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    t_fill             r_fill, n_fill;
    logic              r_sweep_resp, n_sweep_resp;
    logic              r_wr_valid, n_wr_valid;
    logic [ADDR_W-1:0] r_wr_addr, n_wr_addr;
    logic              r_wr_from_mem, n_wr_from_mem;

    // Result registers
    logic               r_out_valid, n_out_valid;
    logic [ROW_W-1:0]   r_out_row, n_out_row;
    logic [COL_W-1:0]   r_out_col, n_out_col;
    logic [CELL_W-1:0]  r_out_value, n_out_value;

    // Memory
    t_mem_req          mem_req;
    logic [CELL_W-1:0] mem_rdata;

    // Decode helpers
    logic              is_newline;
    logic              advance_row;
    logic              at_last_row;
    logic              read_hit;
    logic              need_sweep;
    logic              sweep_last;
    logic [SUM_W-1:0]  sweep_src;
    logic              sweep_src_ok;
    logic [CELL_W-1:0] blank_cell;

    tccs_cell_store u_cell_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // Decode of the latched command
    assign is_newline   = (r_char == NEWLINE_CODE);
    assign advance_row  = is_newline || (r_col == COL_W'(COLUMNS - 1));
    assign at_last_row  = (r_row == ROW_W'(ROWS - 1));
    assign read_hit     = (r_mode == MODE_READ) && (32'(r_idx) < 32'(CELL_COUNT));
    assign need_sweep   = (r_mode == MODE_CLEAR)
                       || ((r_mode == MODE_PUT) && advance_row && at_last_row);
    assign sweep_last   = (r_cnt == CNT_W'(CELL_COUNT));
    assign sweep_src    = SUM_W'(r_cnt) + SUM_W'(COLUMNS);
    assign sweep_src_ok = (sweep_src < SUM_W'(CELL_COUNT));
    assign blank_cell   = {r_color, BLANK_CODE};

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                priority if (read_hit) begin
                    n_state = ST_READ_WAIT;
                end else if (need_sweep) begin
                    n_state = ST_SWEEP;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_READ_WAIT: n_state = ST_IDLE;
            ST_SWEEP: begin
                if (sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath, memory port and result
    always_comb begin
        n_row         = r_row;
        n_col         = r_col;
        n_row_base    = r_row_base;
        n_cnt         = r_cnt;
        n_fill        = r_fill;
        n_sweep_resp  = r_sweep_resp;
        n_wr_valid    = 1'b0;
        n_wr_addr     = r_wr_addr;
        n_wr_from_mem = 1'b0;
        n_out_valid   = 1'b0;
        n_out_row     = r_out_row;
        n_out_col     = r_out_col;
        n_out_value   = '0;

        mem_req.we    = r_wr_valid;
        mem_req.waddr = r_wr_addr;
        mem_req.raddr = (r_state == ST_SWEEP) ? sweep_src[ADDR_W-1:0]
                                              : ADDR_W'(r_idx);
        unique case (r_fill)
            FILL_COPY:  mem_req.wdata = r_wr_from_mem ? mem_rdata : blank_cell;
            FILL_BLANK: mem_req.wdata = blank_cell;
            FILL_ZERO:  mem_req.wdata = '0;
            default:    mem_req.wdata = '0;
        endcase

        unique case (r_state)
            ST_DECODE: begin
                if (r_mode == MODE_PUT) begin
                    // character store at the cursor
                    if (!is_newline) begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = r_row_base + ADDR_W'(r_col);
                        mem_req.wdata = {r_color, r_char};
                    end
                    if (advance_row) begin
                        n_col = '0;
                        if (at_last_row) begin
                            n_cnt        = '0;
                            n_fill       = FILL_COPY;
                            n_sweep_resp = 1'b1;
                        end else begin
                            n_row      = r_row + ROW_W'(1);
                            n_row_base = r_row_base + ADDR_W'(COLUMNS);
                        end
                    end else begin
                        n_col = r_col + COL_W'(1);
                    end
                end else if (r_mode == MODE_CLEAR) begin
                    n_row        = '0;
                    n_col        = '0;
                    n_row_base   = '0;
                    n_cnt        = '0;
                    n_fill       = FILL_BLANK;
                    n_sweep_resp = 1'b1;
                end
                // immediate result unless a read or a sweep follows
                if (!read_hit && !need_sweep) begin
                    n_out_valid = 1'b1;
                    n_out_row   = n_row;
                    n_out_col   = n_col;
                end
            end
            ST_READ_WAIT: begin
                n_out_valid = 1'b1;
                n_out_row   = r_row;
                n_out_col   = r_col;
                n_out_value = mem_rdata;
            end
            ST_SWEEP: begin
                // read one row ahead, write the cell in the next cycle
                if (!sweep_last) begin
                    n_cnt         = r_cnt + CNT_W'(1);
                    n_wr_valid    = 1'b1;
                    n_wr_addr     = r_cnt[ADDR_W-1:0];
                    n_wr_from_mem = sweep_src_ok;
                end else begin
                    n_out_valid = r_sweep_resp;
                    n_out_row   = r_row;
                    n_out_col   = r_col;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SWEEP;
            r_row        <= '0;
            r_col        <= '0;
            r_row_base   <= '0;
            r_color      <= COLOR_AT_RESET;
            r_cnt        <= '0;
            r_fill       <= FILL_ZERO;
            r_sweep_resp <= 1'b0;
            r_wr_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_row        <= n_row;
            r_col        <= n_col;
            r_row_base   <= n_row_base;
            r_cnt        <= n_cnt;
            r_fill       <= n_fill;
            r_sweep_resp <= n_sweep_resp;
            r_wr_valid   <= n_wr_valid;
            r_out_valid  <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_color <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) begin
            r_mode <= i_mode;
            r_char <= i_char_code;
            r_idx  <= i_cell_index;
        end
        r_wr_addr     <= n_wr_addr;
        r_wr_from_mem <= n_wr_from_mem;
        r_out_row     <= n_out_row;
        r_out_col     <= n_out_col;
        r_out_value   <= n_out_value;
    end

    // Ports
    assign o_busy          = (r_state != ST_IDLE) || !i_rst_n;
    assign o_cfg_ready     = i_rst_n;
    assign o_strobe        = r_out_valid && i_rst_n;
    assign o_cursor_row    = OUT_ROW_W'(r_out_row);
    assign o_cursor_column = OUT_COL_W'(r_out_col);
    assign o_cell_value    = r_out_value;

    // Checks
    `TCCS_ASSERT_ALWAYS(a_cursor_range, i_clk, i_rst_n, (32'(r_row) < 32'(ROWS)) && (32'(r_col) < 32'(COLUMNS)), "cursor out of screen")
    `TCCS_ASSERT_ALWAYS(a_row_base, i_clk, i_rst_n, 32'(r_row_base) == 32'(r_row) * 32'(COLUMNS), "row base does not match cursor row")
    `TCCS_ASSERT_IMPLY(a_strobe_idle, i_clk, i_rst_n, r_out_valid, r_state == ST_IDLE, "result shown while busy")
    `TCCS_ASSERT_IMPLY(a_write_phase, i_clk, i_rst_n, mem_req.we, (r_state == ST_SWEEP) || (r_state == ST_DECODE), "cell write outside execute or sweep")
    `TCCS_ASSERT_NEXT(a_accept_decode, i_clk, i_rst_n, i_start && !o_busy, r_state == ST_DECODE && !r_wr_valid, "accepted command not decoded")

endmodule
